// File: sv/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and constants of the LED blink-code controller.
// ----------------------------------------------------------------------------
package lbc_pkg;

  // Lamp modes, also the command target encoding
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_ON    = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  // Classified operations handed from the front to the back
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_TICK  = 3'd1,
    OP_OFF   = 3'd2,
    OP_ON    = 3'd3,
    OP_BLINK = 3'd4
  } op_t;

  // One result item, lamp_on in the lowest bit
  typedef struct packed {
    logic  phase_changed;
    logic  mode_changed;
    logic  lamp_edge;
    logic  phase;
    mode_t mode;
    logic  lamp_on;
  } result_t;

  // Entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

// File: sv/lbc_front.sv
// ----------------------------------------------------------------------------
// lbc_front
// Classify an input item into an operation and clamp its parameters.
// ----------------------------------------------------------------------------
module lbc_front import lbc_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  in_kind,
  input  mode_t                 in_target,
  input  logic [15:0]           in_cycle,
  input  logic [15:0]           in_wait,
  input  logic [7:0]            in_flash,
  output op_t                   op,
  output logic [TIME_BITS-1:0]  period,
  output logic [TIME_BITS-1:0]  pause,
  output logic [COUNT_BITS-1:0] count
);

  always_comb begin
    if (!in_kind) begin
      op = OP_TICK;
    end else begin
      case (in_target)
        MODE_OFF:   op = OP_OFF;
        MODE_ON:    op = OP_ON;
        MODE_BLINK: op = OP_BLINK;
        default:    op = OP_NOP;
      endcase
    end
  end

  // Saturate values wider than the counters
  if (TIME_BITS >= 16) begin : g_time_wide
    assign period = TIME_BITS'(in_cycle);
    assign pause  = TIME_BITS'(in_wait);
  end else begin : g_time_narrow
    assign period = (|in_cycle[15:TIME_BITS]) ? '1 : in_cycle[TIME_BITS-1:0];
    assign pause  = (|in_wait[15:TIME_BITS])  ? '1 : in_wait[TIME_BITS-1:0];
  end

  if (COUNT_BITS >= 8) begin : g_count_wide
    assign count = COUNT_BITS'(in_flash);
  end else begin : g_count_narrow
    assign count = (|in_flash[7:COUNT_BITS]) ? '1 : in_flash[COUNT_BITS-1:0];
  end

endmodule

// File: sv/lbc_queue.sv
// ----------------------------------------------------------------------------
// lbc_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module lbc_queue import lbc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign not_full  = (count_r != CW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entry_r[rd_ptr_r];
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");
  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) && !push |=> count_r == '0)
    else $error("queue count moved without a transfer");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");
`endif

endmodule

// File: sv/lbc_back.sv
// ----------------------------------------------------------------------------
// lbc_back
// Mode machine: carry out and register one operation per cycle unless stalled.
// ----------------------------------------------------------------------------
module lbc_back import lbc_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  mode_t                 cfg_mode,
  input  logic                  q_valid,
  input  op_t                   q_op,
  input  logic [TIME_BITS-1:0]  q_period,
  input  logic [TIME_BITS-1:0]  q_pause,
  input  logic [COUNT_BITS-1:0] q_count,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  mode_t                 mode_r, mode_nxt;
  logic                  lamp_r, lamp_nxt;
  logic                  phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] edges_r, edges_nxt, edges_inc;
  logic [TIME_BITS-1:0]  tgl_r, tgl_nxt, tgl_inc;
  logic [TIME_BITS-1:0]  pse_r, pse_nxt, pse_inc;
  logic [TIME_BITS-1:0]  period_r, period_nxt;
  logic [TIME_BITS-1:0]  pause_r, pause_nxt;
  logic [COUNT_BITS-1:0] code_r, code_nxt;
  logic                  fresh_r;
  logic                  valid_r;
  result_t               res_r, res_nxt;
  logic                  mode_seen;

  assign q_pop     = q_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  assign tgl_inc   = (&tgl_r)   ? tgl_r   : tgl_r + 1'b1;
  assign pse_inc   = (&pse_r)   ? pse_r   : pse_r + 1'b1;
  assign edges_inc = (&edges_r) ? edges_r : edges_r + 1'b1;

  always_comb begin
    mode_nxt   = mode_r;
    lamp_nxt   = lamp_r;
    phase_nxt  = phase_r;
    edges_nxt  = edges_r;
    tgl_nxt    = tgl_r;
    pse_nxt    = pse_r;
    period_nxt = period_r;
    pause_nxt  = pause_r;
    code_nxt   = code_r;
    mode_seen  = 1'b0;
    case (q_op)
      OP_OFF: begin
        mode_nxt  = MODE_OFF;
        mode_seen = 1'b1;
        lamp_nxt  = 1'b0;
      end
      OP_ON: begin
        mode_nxt  = MODE_ON;
        mode_seen = 1'b1;
        lamp_nxt  = 1'b1;
      end
      OP_BLINK: begin
        mode_nxt  = MODE_BLINK;
        mode_seen = 1'b1;
        if (q_period != '0) period_nxt = q_period;
        if (q_pause != '0)  pause_nxt  = q_pause;
        if (q_count != '0)  code_nxt   = q_count;
        edges_nxt = '0;
        phase_nxt = 1'b1;
        pse_nxt   = '0;
        lamp_nxt  = 1'b0;
      end
      OP_TICK: begin
        case (mode_r)
          MODE_OFF: lamp_nxt = 1'b0;
          MODE_ON:  lamp_nxt = 1'b1;
          MODE_BLINK: begin
            if (!phase_r) begin
              if (tgl_inc < period_r) begin
                tgl_nxt = tgl_inc;
              end else begin
                tgl_nxt  = '0;
                lamp_nxt = !lamp_r;
                // falling edge: count it, maybe start the pause
                if (lamp_r) begin
                  if ((code_r == '0) || (edges_inc >= code_r)) begin
                    phase_nxt = 1'b1;
                    pse_nxt   = '0;
                    edges_nxt = '0;
                    if (code_r != '0) begin
                      mode_nxt  = MODE_OFF;
                      mode_seen = 1'b1;
                    end
                  end else begin
                    edges_nxt = edges_inc;
                  end
                end
              end
            end else begin
              pse_nxt = pse_inc;
              if (pse_inc >= pause_r) begin
                phase_nxt = 1'b0;
                tgl_nxt   = '0;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res_nxt.lamp_on       = lamp_nxt;
    res_nxt.mode          = mode_nxt;
    res_nxt.phase         = phase_nxt;
    res_nxt.lamp_edge     = (lamp_nxt != lamp_r);
    res_nxt.mode_changed  = mode_seen;
    res_nxt.phase_changed = (phase_nxt != phase_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      lamp_r   <= 1'b0;
      phase_r  <= 1'b0;
      edges_r  <= '0;
      tgl_r    <= '0;
      pse_r    <= '0;
      period_r <= '0;
      pause_r  <= '0;
      code_r   <= '0;
      fresh_r  <= 1'b1;
      valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r   <= mode_nxt;
        lamp_r   <= lamp_nxt;
        phase_r  <= phase_nxt;
        edges_r  <= edges_nxt;
        tgl_r    <= tgl_nxt;
        pse_r    <= pse_nxt;
        period_r <= period_nxt;
        pause_r  <= pause_nxt;
        code_r   <= code_nxt;
        fresh_r  <= 1'b0;
      end else if (cfg_we && fresh_r) begin
        mode_r <= cfg_mode;
      end
      if (q_pop) begin
        valid_r <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_phase_reported: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (res_r.phase == phase_r) && (res_r.mode == mode_r))
    else $error("registered result disagrees with the mode state");
  a_on_tick_lit: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && (q_op == OP_TICK) && (mode_r == MODE_ON) |=> lamp_r)
    else $error("lamp dark after a tick in on mode");
  a_code_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_BLINK) && (code_r != '0) |-> edges_r < code_r)
    else $error("edge count reached the code length while blinking");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !res_ready |=> valid_r && $stable(res_r))
    else $error("stalled result changed");
`endif

endmodule

// File: sv/led_blink_code_controller_unit.sv
// ----------------------------------------------------------------------------
// Path: an input transfer is written into the queue, popped by the back and
// its result registered in the output register, held there until taken.
// Throughput: one item per cycle, set by the mode machine step, absent stalls.
// A two-entry queue and the output register let input take items while a
// result waits; the input stalls only when both queue entries are full.
// Reset: synchronous, active low; mode idle, lamp dark, counters and
// parameters zero, queue and output empty.
// ----------------------------------------------------------------------------
// led_blink_code_controller_unit
// LED mode controller (idle, off, on, blink-code) driven by ticks and commands.
// ----------------------------------------------------------------------------
module led_blink_code_controller_unit import lbc_pkg::*; #(
  parameter int TIME_BITS  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: start mode, taken only before the first item
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: target_mode[1:0], cycle_ticks[17:2], wait_ticks[33:18],
  // flash_count[41:34], zero fill[47:42]
  input  logic [47:0] in_tdata,
  // tuser: kind (0 tick, 1 command)
  input  logic        in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: lamp_on, mode[2:1], phase, lamp_edge, mode_changed,
  // phase_changed, zero fill[7]
  output logic [7:0]  out_tdata
);

  localparam int OPW = $bits(op_t);
  localparam int QW  = OPW + 2 * TIME_BITS + COUNT_BITS;

  op_t                   f_op, b_op;
  logic [TIME_BITS-1:0]  f_period, f_pause, b_period, b_pause;
  logic [COUNT_BITS-1:0] f_count, b_count;
  logic [QW-1:0]         q_head;
  logic                  q_valid, q_pop;
  result_t               res;

  // Front: classify the transfer and clamp its parameters
  lbc_front #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .in_kind   (in_tuser),
    .in_target (mode_t'(in_tdata[1:0])),
    .in_cycle  (in_tdata[17:2]),
    .in_wait   (in_tdata[33:18]),
    .in_flash  (in_tdata[41:34]),
    .op        (f_op),
    .period    (f_period),
    .pause     (f_pause),
    .count     (f_count)
  );

  // Queue: hold classified operations until the back takes them
  lbc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data ({f_op, f_period, f_pause, f_count}),
    .not_full  (in_tready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign b_op     = op_t'(q_head[QW-1 -: OPW]);
  assign b_period = q_head[COUNT_BITS + 2 * TIME_BITS - 1 -: TIME_BITS];
  assign b_pause  = q_head[COUNT_BITS + TIME_BITS - 1 -: TIME_BITS];
  assign b_count  = q_head[COUNT_BITS-1:0];

  // Back: advance the mode machine, register one result per operation
  lbc_back #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_mode  (mode_t'(cfg_wdata)),
    .q_valid   (q_valid),
    .q_op      (b_op),
    .q_period  (b_period),
    .q_pause   (b_pause),
    .q_count   (b_count),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {1'b0, res};

endmodule
